// ===== hw/rtl/awts_pkg.sv =====
package awts_pkg;

    localparam int IDX_W  = 10;
    localparam int POS_W  = 10;
    localparam int FRAC_W = 17;
    localparam int CUM_W  = 55;
    localparam int ST_W   = 2;
    localparam int ACT_W  = 2;

    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic signed [POS_W-1:0]  pos_t;
    typedef logic [FRAC_W-1:0]        frac_t;
    typedef logic [CUM_W-1:0]         cum_t;
    typedef logic [ST_W-1:0]          status_t;
    typedef logic [ACT_W-1:0]         action_t;

    localparam frac_t ONE_FRAC = 17'd65536;

    localparam action_t ACT_VERTEX = 2'd0;
    localparam action_t ACT_APPEND = 2'd1;
    localparam action_t ACT_QUERY  = 2'd2;
    localparam action_t ACT_CLEAR  = 2'd3;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;

    function automatic cum_t sat_add(input cum_t a, input cum_t b);
        logic [CUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CUM_W] ? {CUM_W{1'b1}} : s[CUM_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/area_weighted_triangle_sampler.sv =====
// Channel  | Handshake         | Payload
// ---------+-------------------+---------------------------------------------------
// s_       | s_valid, s_ready  | action, vertex_index, pos_x/y/z, corner_a/b/c, frac
// m_       | m_valid, m_ready  | pick_a, pick_b, pick_c, status
//
// An append does three vertex memory reads, then nine passes through the one shared
// multiplier. A query does one cumulative weight memory read per binary search step.
// Synchronous active-low reset empties the triangle table; memories are not cleared.
// One transaction is in flight at a time; the next is taken while a result
// waits in the output register.
module area_weighted_triangle_sampler #(
    parameter int VERTEX_DEPTH   = 1024,
    parameter int TRIANGLE_DEPTH = 1024,
    parameter int COORD_BITS     = 10
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  awts_pkg::action_t s_action,
    input  awts_pkg::idx_t    s_vertex_index,
    input  awts_pkg::pos_t    s_pos_x,
    input  awts_pkg::pos_t    s_pos_y,
    input  awts_pkg::pos_t    s_pos_z,
    input  awts_pkg::idx_t    s_corner_a,
    input  awts_pkg::idx_t    s_corner_b,
    input  awts_pkg::idx_t    s_corner_c,
    input  awts_pkg::frac_t   s_uniform_frac,
    output logic              m_valid,
    input  logic              m_ready,
    output awts_pkg::idx_t    m_pick_a,
    output awts_pkg::idx_t    m_pick_b,
    output awts_pkg::idx_t    m_pick_c,
    output awts_pkg::status_t m_status
);
    import awts_pkg::*;

    localparam int VMEM = (VERTEX_DEPTH < (1 << IDX_W)) ? VERTEX_DEPTH : (1 << IDX_W);
    localparam int VAW  = $clog2(VMEM);
    localparam int TAW  = (TRIANGLE_DEPTH > 1) ? $clog2(TRIANGLE_DEPTH) : 1;
    localparam int CNW  = $clog2(TRIANGLE_DEPTH + 1);
    localparam int CXW  = (COORD_BITS > POS_W) ? COORD_BITS : POS_W;
    localparam int VW   = 3 * COORD_BITS;
    localparam int DW   = COORD_BITS + 1;
    localparam int OW   = 2 * COORD_BITS + 3;
    localparam int PW   = 2 * OW;
    localparam int TW   = 3 * IDX_W;
    localparam int FTW  = CUM_W + FRAC_W;
    localparam int LOW  = 32 + FRAC_W;
    localparam int HIW  = CUM_W - 32 + FRAC_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ARDB = 4'd1;
    localparam logic [3:0] S_ARDC = 4'd2;
    localparam logic [3:0] S_ADIF = 4'd3;
    localparam logic [3:0] S_AMUL = 4'd4;
    localparam logic [3:0] S_AWR  = 4'd5;
    localparam logic [3:0] S_QSUM = 4'd6;
    localparam logic [3:0] S_QSRC = 4'd7;
    localparam logic [3:0] S_QCRN = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;

    logic [VW-1:0]   vtx_mem [VMEM];
    logic [TW-1:0]   tri_mem [TRIANGLE_DEPTH];
    cum_t            cum_mem [TRIANGLE_DEPTH];

    logic [3:0]      state_reg, state_next;
    logic [CNW-1:0]  count_reg, count_next;
    cum_t            total_reg, total_next;
    logic            m_valid_reg, m_valid_next;

    logic [VW-1:0]   vtx_rd_reg;
    logic [TW-1:0]   tri_rd_reg;
    cum_t            cum_rd_reg;
    logic [VAW-1:0]  vaddr;
    logic [TAW-1:0]  tri_raddr, cum_raddr;
    logic            vtx_we, tri_we;
    logic [VW-1:0]   vtx_wdata;
    cum_t            cum_wdata;

    idx_t            ca_reg, ca_next, cb_reg, cb_next, cc_reg, cc_next;
    logic [2:0]      oor_reg, oor_next;
    logic [VW-1:0]   va_reg, va_next, vb_reg, vb_next;
    logic signed [COORD_BITS-1:0] a_c [3];
    logic signed [COORD_BITS-1:0] b_c [3];
    logic signed [COORD_BITS-1:0] c_c [3];
    logic [VW-1:0]   vc_raw;
    logic signed [DW-1:0] u_reg [3];
    logic signed [DW-1:0] u_next [3];
    logic signed [DW-1:0] v_reg [3];
    logic signed [DW-1:0] v_next [3];
    logic [3:0]      mstep_reg, mstep_next, ps_reg, ps_next;
    logic            pv_reg, pv_next;
    logic signed [OW-1:0] opa, opb;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic signed [OW-1:0] hold_reg, hold_next;
    logic signed [OW-1:0] cross_reg [3];
    logic signed [OW-1:0] cross_next [3];
    logic signed [PW-1:0] cross_diff;
    cum_t            wsum_reg, wsum_next, prev_w;

    frac_t           frac_sat;
    logic [LOW-1:0]  ftl_reg, ftl_next;
    logic [HIW-1:0]  fth_reg, fth_next;
    logic [FTW-1:0]  ft_reg, ft_next;
    logic [TAW-1:0]  lo_reg, lo_next, hi_reg, hi_next, mid_reg, mid_next;
    logic [TAW-1:0]  lo_s, hi_s, hi0;
    logic            reach;

    idx_t            res_a_reg, res_a_next, res_b_reg, res_b_next, res_c_reg, res_c_next;
    status_t         res_st_reg, res_st_next;
    idx_t            m_a_reg, m_b_reg, m_c_reg;
    status_t         m_st_reg;
    logic            out_free;

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_pick_a = m_a_reg;
    assign m_pick_b = m_b_reg;
    assign m_pick_c = m_c_reg;
    assign m_status = m_st_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            a_c[k] = va_reg[(2-k)*COORD_BITS +: COORD_BITS];
            b_c[k] = vb_reg[(2-k)*COORD_BITS +: COORD_BITS];
            c_c[k] = vc_raw[(2-k)*COORD_BITS +: COORD_BITS];
        end
    end
    assign vc_raw = oor_reg[2] ? '0 : vtx_rd_reg;

    always_comb begin
        opa = '0;
        opb = '0;
        case (mstep_reg)
            4'd0: begin opa = OW'(u_reg[1]); opb = OW'(v_reg[2]); end
            4'd1: begin opa = OW'(u_reg[2]); opb = OW'(v_reg[1]); end
            4'd2: begin opa = OW'(u_reg[2]); opb = OW'(v_reg[0]); end
            4'd3: begin opa = OW'(u_reg[0]); opb = OW'(v_reg[2]); end
            4'd4: begin opa = OW'(u_reg[0]); opb = OW'(v_reg[1]); end
            4'd5: begin opa = OW'(u_reg[1]); opb = OW'(v_reg[0]); end
            4'd6: begin opa = cross_reg[0]; opb = cross_reg[0]; end
            4'd7: begin opa = cross_reg[1]; opb = cross_reg[1]; end
            4'd8: begin opa = cross_reg[2]; opb = cross_reg[2]; end
            default: begin opa = '0; opb = '0; end
        endcase
    end

    assign cross_diff = PW'(hold_reg) - prod_reg;
    assign frac_sat   = (s_uniform_frac > ONE_FRAC) ? ONE_FRAC : s_uniform_frac;
    assign prev_w     = (count_reg != '0) ? total_reg : '0;
    assign hi0        = TAW'(count_reg - 1'b1);
    assign reach      = ({1'b0, cum_rd_reg, 16'b0} >= ft_reg);
    assign lo_s       = reach ? lo_reg : TAW'(mid_reg + 1'b1);
    assign hi_s       = reach ? mid_reg : hi_reg;

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        total_next   = total_reg;
        m_valid_next = m_valid_reg;
        ca_next      = ca_reg;
        cb_next      = cb_reg;
        cc_next      = cc_reg;
        oor_next     = oor_reg;
        va_next      = va_reg;
        vb_next      = vb_reg;
        u_next       = u_reg;
        v_next       = v_reg;
        mstep_next   = mstep_reg;
        ps_next      = ps_reg;
        pv_next      = 1'b0;
        prod_next    = opa * opb;
        hold_next    = hold_reg;
        cross_next   = cross_reg;
        wsum_next    = wsum_reg;
        ftl_next     = ftl_reg;
        fth_next     = fth_reg;
        ft_next      = ft_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        res_a_next   = res_a_reg;
        res_b_next   = res_b_reg;
        res_c_next   = res_c_reg;
        res_st_next  = res_st_reg;
        vaddr        = VAW'(s_corner_a);
        tri_raddr    = lo_reg;
        cum_raddr    = mid_reg;
        vtx_we       = 1'b0;
        tri_we       = 1'b0;
        vtx_wdata    = {COORD_BITS'(CXW'(s_pos_x)), COORD_BITS'(CXW'(s_pos_y)),
                        COORD_BITS'(CXW'(s_pos_z))};
        cum_wdata    = sat_add(prev_w, wsum_reg);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                ca_next     = s_corner_a;
                cb_next     = s_corner_b;
                cc_next     = s_corner_c;
                oor_next    = {32'(s_corner_c) >= VERTEX_DEPTH,
                               32'(s_corner_b) >= VERTEX_DEPTH,
                               32'(s_corner_a) >= VERTEX_DEPTH};
                ftl_next    = {{(LOW-32){1'b0}}, total_reg[31:0]} *
                              {{(LOW-FRAC_W){1'b0}}, frac_sat};
                fth_next    = {{FRAC_W{1'b0}}, total_reg[CUM_W-1:32]} *
                              {{(HIW-FRAC_W){1'b0}}, frac_sat};
                res_a_next  = '0;
                res_b_next  = '0;
                res_c_next  = '0;
                res_st_next = ST_OK;
                if (s_valid) begin
                    unique case (s_action)
                        ACT_VERTEX: begin
                            vtx_we     = (32'(s_vertex_index) < VERTEX_DEPTH);
                            vaddr      = VAW'(s_vertex_index);
                            state_next = S_FIN;
                        end
                        ACT_APPEND: begin
                            if (count_reg >= CNW'(TRIANGLE_DEPTH)) begin
                                res_st_next = ST_FULL;
                                state_next  = S_FIN;
                            end else begin
                                state_next = S_ARDB;
                            end
                        end
                        ACT_QUERY: begin
                            if (count_reg == '0) begin
                                res_st_next = ST_EMPTY;
                                state_next  = S_FIN;
                            end else begin
                                state_next = S_QSUM;
                            end
                        end
                        ACT_CLEAR: begin
                            count_next = '0;
                            state_next = S_FIN;
                        end
                        default: state_next = S_FIN;
                    endcase
                end
            end
            S_ARDB: begin
                vaddr      = VAW'(cb_reg);
                va_next    = oor_reg[0] ? '0 : vtx_rd_reg;
                state_next = S_ARDC;
            end
            S_ARDC: begin
                vaddr      = VAW'(cc_reg);
                vb_next    = oor_reg[1] ? '0 : vtx_rd_reg;
                state_next = S_ADIF;
            end
            S_ADIF: begin
                for (int k = 0; k < 3; k++) begin
                    u_next[k] = DW'(b_c[k]) - DW'(a_c[k]);
                    v_next[k] = DW'(c_c[k]) - DW'(a_c[k]);
                end
                mstep_next = '0;
                wsum_next  = '0;
                state_next = S_AMUL;
            end
            S_AMUL: begin
                pv_next = (mstep_reg <= 4'd8);
                ps_next = mstep_reg;
                if (mstep_reg <= 4'd8) begin
                    mstep_next = mstep_reg + 1'b1;
                end
                if (pv_reg) begin
                    case (ps_reg) inside
                        4'd0, 4'd2, 4'd4: hold_next = OW'(prod_reg);
                        4'd1: cross_next[0] = OW'(cross_diff);
                        4'd3: cross_next[1] = OW'(cross_diff);
                        4'd5: cross_next[2] = OW'(cross_diff);
                        4'd6, 4'd7, 4'd8: wsum_next = sat_add(wsum_reg, CUM_W'(prod_reg));
                        default: hold_next = hold_reg;
                    endcase
                    if (ps_reg == 4'd8) begin
                        state_next = S_AWR;
                    end
                end
            end
            S_AWR: begin
                tri_we     = 1'b1;
                total_next = cum_wdata;
                count_next = count_reg + 1'b1;
                state_next = S_FIN;
            end
            S_QSUM: begin
                ft_next = {{(FTW-LOW){1'b0}}, ftl_reg} + {fth_reg, 32'b0};
                lo_next = '0;
                hi_next = hi0;
                if (hi0 == '0) begin
                    tri_raddr  = '0;
                    state_next = S_QCRN;
                end else begin
                    mid_next   = hi0 >> 1;
                    cum_raddr  = hi0 >> 1;
                    state_next = S_QSRC;
                end
            end
            S_QSRC: begin
                lo_next = lo_s;
                hi_next = hi_s;
                if (lo_s < hi_s) begin
                    mid_next  = lo_s + ((hi_s - lo_s) >> 1);
                    cum_raddr = lo_s + ((hi_s - lo_s) >> 1);
                end else begin
                    tri_raddr  = lo_s;
                    state_next = S_QCRN;
                end
            end
            S_QCRN: begin
                res_a_next = tri_rd_reg[3*IDX_W-1:2*IDX_W];
                res_b_next = tri_rd_reg[2*IDX_W-1:IDX_W];
                res_c_next = tri_rd_reg[IDX_W-1:0];
                state_next = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ca_reg     <= ca_next;
        cb_reg     <= cb_next;
        cc_reg     <= cc_next;
        oor_reg    <= oor_next;
        va_reg     <= va_next;
        vb_reg     <= vb_next;
        u_reg      <= u_next;
        v_reg      <= v_next;
        mstep_reg  <= mstep_next;
        ps_reg     <= ps_next;
        pv_reg     <= pv_next;
        prod_reg   <= prod_next;
        hold_reg   <= hold_next;
        cross_reg  <= cross_next;
        wsum_reg   <= wsum_next;
        ftl_reg    <= ftl_next;
        fth_reg    <= fth_next;
        ft_reg     <= ft_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        res_a_reg  <= res_a_next;
        res_b_reg  <= res_b_next;
        res_c_reg  <= res_c_next;
        res_st_reg <= res_st_next;
        if (state_reg == S_FIN && out_free) begin
            m_a_reg  <= res_a_reg;
            m_b_reg  <= res_b_reg;
            m_c_reg  <= res_c_reg;
            m_st_reg <= res_st_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (vtx_we) begin
            vtx_mem[vaddr] <= vtx_wdata;
        end
        vtx_rd_reg <= vtx_mem[vaddr];
    end

    always_ff @(posedge aclk) begin
        if (tri_we) begin
            tri_mem[count_reg[TAW-1:0]] <= {ca_reg, cb_reg, cc_reg};
        end
        tri_rd_reg <= tri_mem[tri_raddr];
    end

    always_ff @(posedge aclk) begin
        if (tri_we) begin
            cum_mem[count_reg[TAW-1:0]] <= cum_wdata;
        end
        cum_rd_reg <= cum_mem[cum_raddr];
    end

endmodule

// ===== hw/rtl/awts_checker.sv =====
module awts_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input awts_pkg::action_t s_action,
    input awts_pkg::idx_t    s_vertex_index,
    input awts_pkg::pos_t    s_pos_x,
    input awts_pkg::pos_t    s_pos_y,
    input awts_pkg::pos_t    s_pos_z,
    input awts_pkg::idx_t    s_corner_a,
    input awts_pkg::idx_t    s_corner_b,
    input awts_pkg::idx_t    s_corner_c,
    input awts_pkg::frac_t   s_uniform_frac,
    input logic              m_valid,
    input logic              m_ready,
    input awts_pkg::idx_t    m_pick_a,
    input awts_pkg::idx_t    m_pick_b,
    input awts_pkg::idx_t    m_pick_c,
    input awts_pkg::status_t m_status
);
    import awts_pkg::*;

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid &&
        $stable({s_action, s_vertex_index, s_pos_x, s_pos_y, s_pos_z,
                 s_corner_a, s_corner_b, s_corner_c, s_uniform_frac}))
        else $error("input transaction changed while waiting");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid &&
        $stable({m_pick_a, m_pick_b, m_pick_c, m_status}))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status == ST_OK || m_status == ST_FULL || m_status == ST_EMPTY)
        else $error("undefined status code");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_pick_a == '0 && m_pick_b == '0 &&
        m_pick_c == '0)
        else $error("nonzero picks on failed transaction");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transaction taken while one in flight");

endmodule

bind area_weighted_triangle_sampler awts_checker u_awts_checker (.*);
